// File: design/cla_pkg.sv
// Shared types and constants for the comment lane allocator.
// Used by the top level and by the iterative divider; no dependencies.
package cla_pkg;

  localparam int CLA_MAX_LANES = 64;

  // Widths of the arithmetic path.
  localparam int NUM_W = 38;  // 16 x 22 bit products
  localparam int DEN_W = 23;  // screen width plus pixel length
  localparam int QUO_W = 16;  // quotients never exceed the scroll time
  localparam int LEN_W = 22;  // pixel length of a comment

  // Comment kinds.
  localparam logic [1:0] KIND_SCROLL = 2'd0;
  localparam logic [1:0] KIND_TOP    = 2'd1;
  localparam logic [1:0] KIND_BOTTOM = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_LANE_COUNT = 3'd0;
  localparam logic [2:0] REG_SCROLL_T   = 3'd1;
  localparam logic [2:0] REG_FIXED_T    = 3'd2;
  localparam logic [2:0] REG_FONT_SCALE = 3'd3;
  localparam logic [2:0] REG_SCREEN_W   = 3'd4;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } cla_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quot;
  } cla_div_rsp_t;

endpackage

// File: design/comment_lane_allocator_core.sv
// Comment lane allocator. Each request carries one comment and yields one result
// (placed flag, lane). Lanes are scanned one at a time from 0: a top or bottom lane
// takes a table read and a check; a scrolling lane that is occupied takes more,
// since its entry time needs a 16-step division on the shared divider; a scrolling
// comment first has a setup of its own. One 22 x 16 multiplier and one divider serve
// all arithmetic, and the lane table is a single-port memory read once per lane.
// The block takes no new request until the previous one has finished its scan.
module comment_lane_allocator_core
  import cla_pkg::*;
#(
  parameter int MAX_LANES = CLA_MAX_LANES
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // start_time_ms[31:0], text_length[41:32], glyph_size[49:42]
  input  logic [1:0]  s_tuser,  // op[1:0]
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // lane[5:0]
  output logic        m_tuser   // placed
);

  localparam int DEPTH = 3 * MAX_LANES;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(MAX_LANES + 1);
  localparam int CW    = (LW > 7) ? LW : 7;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_FPX    = 15'h0002,
    S_LEN    = 15'h0004,
    S_WT     = 15'h0008,
    S_LGO    = 15'h0010,
    S_LWAIT  = 15'h0020,
    S_RD     = 15'h0040,
    S_CHK    = 15'h0080,
    S_OFPX   = 15'h0100,
    S_OLEN   = 15'h0200,
    S_OTL    = 15'h0400,
    S_OGO    = 15'h0800,
    S_OWAIT  = 15'h1000,
    S_CMP    = 15'h2000,
    S_FIN    = 15'h4000
  } state_t;

  state_t state, state_next;

  // Registers
  logic [6:0]  lane_count;
  logic [15:0] scroll_t;
  logic [15:0] fixed_t;
  logic [11:0] font_scale;
  logic [13:0] screen_w;

  logic        wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_count <= 7'd16;
      scroll_t   <= 16'd8000;
      fixed_t    <= 16'd4000;
      font_scale <= 12'd256;
      screen_w   <= 14'd1920;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_LANE_COUNT: lane_count <= pwdata[6:0];
        REG_SCROLL_T:   scroll_t   <= pwdata[15:0];
        REG_FIXED_T:    fixed_t    <= pwdata[15:0];
        REG_FONT_SCALE: font_scale <= pwdata[11:0];
        REG_SCREEN_W:   screen_w   <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_LANE_COUNT: prdata = {25'd0, lane_count};
      REG_SCROLL_T:   prdata = {16'd0, scroll_t};
      REG_FIXED_T:    prdata = {16'd0, fixed_t};
      REG_FONT_SCALE: prdata = {20'd0, font_scale};
      REG_SCREEN_W:   prdata = {18'd0, screen_w};
      default:        prdata = '0;
    endcase
  end

  // Request held for the whole scan
  logic [1:0]  kind;
  logic [31:0] ts;
  logic [9:0]  tl;
  logic [7:0]  fs;
  logic [LEN_W-1:0] new_len;
  logic [LEN_W-1:0] occ_len;
  logic [QUO_W-1:0] left_off;
  logic [LW-1:0] lane_idx;
  logic [LW-1:0] lane_lim;
  logic          placed_r;

  logic accept;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;

  assign lane_lim = (CW'(lane_count) > CW'(MAX_LANES)) ? LW'(MAX_LANES) : LW'(lane_count);

  // Lane table: one write and one registered read per cycle.
  logic [49:0]    mem [DEPTH];
  logic [49:0]    rd_data;
  logic [DEPTH-1:0] occ;
  logic           occ_q;
  logic [AW-1:0]  slot;
  logic           place;
  logic [31:0]    occ_ts;
  logic [9:0]     occ_tl;
  logic [7:0]     occ_fs;

  assign slot   = AW'(kind) * AW'(MAX_LANES) + AW'(lane_idx);
  assign occ_ts = rd_data[31:0];
  assign occ_tl = rd_data[41:32];
  assign occ_fs = rd_data[49:42];

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      rd_data <= mem[slot];
    end
    if (place) begin
      mem[slot] <= {fs, tl, ts};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ   <= '0;
      occ_q <= 1'b0;
    end else begin
      if (state == S_RD) begin
        occ_q <= occ[slot];
      end
      if (place) begin
        occ[slot] <= 1'b1;
      end
    end
  end

  // Shared multiplier with a registered product
  logic [LEN_W-1:0] mul_a;
  logic [15:0]      mul_b;
  logic [NUM_W-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_FPX:  begin mul_a = LEN_W'(fs);      mul_b = 16'(font_scale); end
      S_LEN:  begin mul_a = LEN_W'(tl);      mul_b = 16'(mul_p[19:8]); end
      S_WT:   begin mul_a = LEN_W'(screen_w); mul_b = scroll_t; end
      S_OFPX: begin mul_a = LEN_W'(occ_fs);  mul_b = 16'(font_scale); end
      S_OLEN: begin mul_a = LEN_W'(occ_tl);  mul_b = 16'(mul_p[19:8]); end
      S_OTL:  begin mul_a = mul_p[LEN_W-1:0]; mul_b = scroll_t; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= NUM_W'(mul_a * mul_b);
  end

  // Divider
  cla_div_req_t div_req;
  cla_div_rsp_t div_rsp;

  always_comb begin
    div_req.start = (state == S_LGO) || (state == S_OGO);
    div_req.num   = mul_p;
    div_req.den   = (state == S_LGO) ? DEN_W'(screen_w) + DEN_W'(new_len)
                                     : DEN_W'(screen_w) + DEN_W'(occ_len);
  end

  cla_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Freedom tests, with one bit of headroom on every sum
  logic fixed_free;
  logic scroll_free;
  assign fixed_free  = {1'b0, ts} > ({1'b0, occ_ts} + 33'(fixed_t));
  assign scroll_free = ({1'b0, ts} > ({1'b0, occ_ts} + 33'(div_rsp.quot))) &&
                       (({1'b0, ts} + 33'(left_off)) > ({1'b0, occ_ts} + 33'(scroll_t)));

  logic last_lane;
  assign last_lane = (LW'(lane_idx + 1'b1) == lane_lim);

  always_comb begin
    state_next = state;
    place      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((s_tuser != KIND_SCROLL) && (s_tuser != KIND_TOP) && (s_tuser != KIND_BOTTOM)) begin
            state_next = S_FIN;
          end else if ((s_tuser == KIND_SCROLL) ? (scroll_t == '0) : (fixed_t == '0)) begin
            state_next = S_FIN;
          end else if (lane_lim == '0) begin
            state_next = S_FIN;
          end else if (s_tuser == KIND_SCROLL) begin
            state_next = S_FPX;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_FPX:   state_next = S_LEN;
      S_LEN:   state_next = S_WT;
      S_WT:    state_next = S_LGO;
      S_LGO:   state_next = S_LWAIT;
      S_LWAIT: if (div_rsp.done) state_next = S_RD;
      S_RD:    state_next = S_CHK;
      S_CHK: begin
        if (!occ_q || ((kind != KIND_SCROLL) && fixed_free)) begin
          place      = 1'b1;
          state_next = S_FIN;
        end else if (kind == KIND_SCROLL) begin
          state_next = S_OFPX;
        end else begin
          state_next = last_lane ? S_FIN : S_RD;
        end
      end
      S_OFPX:  state_next = S_OLEN;
      S_OLEN:  state_next = S_OTL;
      S_OTL:   state_next = S_OGO;
      S_OGO:   state_next = S_OWAIT;
      S_OWAIT: if (div_rsp.done) state_next = S_CMP;
      S_CMP: begin
        if (scroll_free) begin
          place      = 1'b1;
          state_next = S_FIN;
        end else begin
          state_next = last_lane ? S_FIN : S_RD;
        end
      end
      S_FIN:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      placed_r <= 1'b0;
      lane_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        placed_r <= 1'b0;
        lane_idx <= '0;
      end else if (place) begin
        placed_r <= 1'b1;
      end else if (((state == S_CHK) && (state_next == S_RD)) ||
                   ((state == S_CMP) && (state_next == S_RD))) begin
        lane_idx <= lane_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= s_tuser;
      ts   <= s_tdata[31:0];
      tl   <= s_tdata[41:32];
      fs   <= s_tdata[49:42];
    end
    if (state == S_WT) begin
      new_len <= mul_p[LEN_W-1:0];
    end
    if (state == S_OTL) begin
      occ_len <= mul_p[LEN_W-1:0];
    end
    if (state == S_LWAIT && div_rsp.done) begin
      left_off <= div_rsp.quot;
    end
    if (state == S_FIN && (!m_tvalid || m_tready)) begin
      m_tuser <= placed_r;
      m_tdata <= {2'b00, placed_r ? 6'(lane_idx) : 6'd0};
    end
  end

endmodule

// File: design/cla_div.sv
// Restoring divider, one quotient bit per cycle, for the lane allocator.
// Depends on cla_pkg. The caller guarantees num < den * 2**16.
module cla_div
  import cla_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cla_div_req_t req,
  output cla_div_rsp_t rsp
);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [QUO_W-1:0] q;
  logic [4:0]       cnt;
  logic             busy;
  logic             done;
  logic             den_zero;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, q[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= {1'b0, req.num[NUM_W-1:QUO_W]};
      q        <= req.num[QUO_W-1:0];
      den_r    <= req.den;
      den_zero <= (req.den == '0);
    end else if (busy) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      q   <= {q[QUO_W-2:0], ge};
    end
  end

  // A zero divisor only arises with a zero numerator; its quotient is zero.
  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = den_zero ? '0 : q;

endmodule

// File: design/cla_chk.sv
// Port-level checks for the comment lane allocator, bound to the top level.
// Depends only on the top level's ports.
module cla_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);

  // A result that is not taken holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // An unplaced comment always reports lane zero.
  a_unplaced: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 8'd0)
    else $error("unplaced result with nonzero lane");

  // The lane field never uses the padding bits.
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:6] == 2'b00)
    else $error("padding bits set");

  // After a request is taken the block is busy for at least the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken back to back");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind comment_lane_allocator_core cla_chk u_cla_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: tb/comment_lane_allocator_core_tb.sv
// Self-checking testbench for comment_lane_allocator_core.
// Predicts lane placement per comment and checks every result; needs cla_pkg and the core.
`timescale 1ns / 100ps

module comment_lane_allocator_core_tb;
  import cla_pkg::*;

  localparam int LANES_MAX = 64;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic       placed;
    logic [5:0] lane;
  } placement_t;

  // Holds the lane table copy and the queue of expected placements.
  class placement_board;
    logic [6:0]  lane_count;
    logic [15:0] scroll_ms;
    logic [15:0] fixed_ms;
    logic [11:0] scale_q8;
    logic [13:0] width_px;
    logic [31:0] occ_start [3*LANES_MAX];
    logic [9:0]  occ_chars [3*LANES_MAX];
    logic [7:0]  occ_font [3*LANES_MAX];
    bit          occ_valid [3*LANES_MAX];
    placement_t  pending [$];
    int          errors;

    function new();
      lane_count = 16;
      scroll_ms = 8000;
      fixed_ms = 4000;
      scale_q8 = 256;
      width_px = 1920;
      errors = 0;
      foreach (occ_valid[i]) occ_valid[i] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_LANE_COUNT: lane_count = val[6:0];
        REG_SCROLL_T:   scroll_ms = val[15:0];
        REG_FIXED_T:    fixed_ms = val[15:0];
        REG_FONT_SCALE: scale_q8 = val[11:0];
        REG_SCREEN_W:   width_px = val[13:0];
        default: ;
      endcase
    endfunction

    function longint unsigned pixels(logic [9:0] chars, logic [7:0] fsize);
      longint unsigned fpx;
      fpx = (longint'(fsize) * longint'(scale_q8)) >> 8;
      return longint'(chars) * fpx;
    endfunction

    function longint unsigned quot(longint unsigned num, longint unsigned den);
      return den == 0 ? 0 : num / den;
    endfunction

    function bit slot_free(logic [1:0] kind, int slot, logic [31:0] ts, logic [9:0] tl,
                           logic [7:0] fs);
      longint unsigned t, w, ol, nl, entered, leaves;
      if (!occ_valid[slot]) return 1;
      if (kind != KIND_SCROLL)
        return longint'(ts) > longint'(occ_start[slot]) + longint'(fixed_ms);
      t = scroll_ms;
      w = width_px;
      ol = pixels(occ_chars[slot], occ_font[slot]);
      nl = pixels(tl, fs);
      entered = longint'(occ_start[slot]) + quot(t * ol, w + ol);
      leaves = longint'(ts) + quot(w * t, w + nl);
      return longint'(ts) > entered && leaves > longint'(occ_start[slot]) + t;
    endfunction

    function void note_comment(logic [1:0] kind, logic [31:0] ts, logic [9:0] tl,
                               logic [7:0] fs);
      placement_t r;
      int lanes, slot;
      r = '0;
      lanes = lane_count > LANES_MAX ? LANES_MAX : lane_count;
      if (kind <= KIND_BOTTOM &&
          ((kind == KIND_SCROLL) ? scroll_ms != 0 : fixed_ms != 0)) begin
        for (int i = 0; i < lanes; i++) begin
          slot = kind * LANES_MAX + i;
          if (slot_free(kind, slot, ts, tl, fs)) begin
            occ_start[slot] = ts;
            occ_chars[slot] = tl;
            occ_font[slot] = fs;
            occ_valid[slot] = 1;
            r.placed = 1;
            r.lane = i[5:0];
            break;
          end
        end
      end
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(logic placed, logic [7:0] data);
      placement_t e;
      if (pending.size() == 0) begin
        report_error($sformatf("unexpected result placed=%0d lane=%0d", placed, data));
        return;
      end
      e = pending.pop_front();
      if (placed !== e.placed)
        report_error($sformatf("placed %0d, expected %0d", placed, e.placed));
      if (data !== {2'b00, e.lane})
        report_error($sformatf("lane %0d, expected %0d", data, e.lane));
    endfunction

    function void report_error(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [7:0]  m_tdata;
  logic        m_tuser;

  placement_board board;
  longint cycles = 0;
  bit hold_sink = 0;
  bit sink_wild = 1;
  int placements = 0;

  comment_lane_allocator_core dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("comment_lane_allocator_core test failed");
      $finish;
    end
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side: stalls of random length, plus a long hold-off when asked.
  initial begin
    int stall;
    stall = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        board.check_result(m_tuser, m_tdata);
        if (m_tuser) placements++;
      end
      if (stall == 0 && sink_wild && $urandom_range(0, 3) == 0) stall = gap_len();
      if (hold_sink || stall > 0) m_tready <= 0;
      else m_tready <= 1;
      if (stall > 0) stall--;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.write_reg(idx, val);
  endtask

  // The valid line is dropped only before a gap, so a request can follow at once.
  task automatic send_comment(logic [1:0] kind, logic [31:0] ts, logic [9:0] tl,
                              logic [7:0] fs, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= kind;
    s_tdata <= {6'b0, fs, tl, ts};
    do @(posedge clk); while (!s_tready);
    board.note_comment(kind, ts, tl, fs);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Comments come in bursts with rising times so lanes fill and free again.
  task automatic random_burst(int count, ref logic [31:0] clock_ms, input int step_max);
    logic [1:0] kind;
    logic [9:0] tl;
    logic [7:0] fs;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 15) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      clock_ms = clock_ms + $urandom_range(0, step_max);
      tl = $urandom_range(0, 9) == 0 ? 10'($urandom) : 10'($urandom_range(0, 40));
      fs = $urandom_range(0, 9) == 0 ? 8'($urandom_range(1, 255)) : 8'($urandom_range(18, 36));
      send_comment(kind, $urandom_range(0, 19) == 0 ? $urandom : clock_ms, tl, fs, 0);
    end
  endtask

  initial begin
    logic [31:0] now_ms;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes, every kind, unknown kind, full table.
    write_reg(REG_LANE_COUNT, 2);
    send_comment(KIND_SCROLL, 0, 0, 1, 0);
    send_comment(KIND_SCROLL, 0, 1023, 255, 0);
    send_comment(KIND_SCROLL, 0, 5, 20, 0);
    send_comment(KIND_SCROLL, 32'hFFFF_FFFF, 1023, 255, 0);
    send_comment(KIND_TOP, 100, 10, 25, 0);
    send_comment(KIND_TOP, 100, 10, 25, 0);
    send_comment(KIND_TOP, 100, 10, 25, 0);
    send_comment(KIND_TOP, 5000, 10, 25, 0);
    send_comment(KIND_BOTTOM, 32'hFFFF_FFFF, 0, 255, 0);
    send_comment(KIND_BOTTOM, 32'h8000_0000, 1023, 1, 0);
    send_comment(2'd3, 32'h5555_AAAA, 10'h2AA, 8'hAA, 0);
    send_comment(KIND_SCROLL, 20000, 10'h155, 8'h55, 0);
    drain();
    // Disabled kinds, no lanes, over-range lane count, zero divisor, unknown register.
    write_reg(REG_SCROLL_T, 0);
    write_reg(REG_FIXED_T, 0);
    send_comment(KIND_SCROLL, 1, 1, 1, 0);
    send_comment(KIND_TOP, 1, 1, 1, 0);
    drain();
    write_reg(REG_SCROLL_T, 65535);
    write_reg(REG_FIXED_T, 65535);
    write_reg(REG_LANE_COUNT, 0);
    send_comment(KIND_BOTTOM, 1, 1, 1, 0);
    drain();
    write_reg(REG_LANE_COUNT, 127);
    write_reg(REG_SCREEN_W, 0);
    write_reg(3'd5, 32'hFFFF_FFFF);
    write_reg(REG_FONT_SCALE, 4095);
    send_comment(KIND_SCROLL, 10, 0, 9, 0);
    send_comment(KIND_SCROLL, 10, 0, 9, 0);
    send_comment(KIND_SCROLL, 10, 3, 9, 0);
    drain();
    write_reg(REG_FONT_SCALE, 1);
    write_reg(REG_SCREEN_W, 16383);
    send_comment(KIND_SCROLL, 30, 7, 255, 0);
    drain();

    // Random phases across several register settings.
    now_ms = 0;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 6)
        0: begin
          write_reg(REG_LANE_COUNT, 16); write_reg(REG_SCROLL_T, 8000);
          write_reg(REG_FIXED_T, 4000); write_reg(REG_FONT_SCALE, 256);
          write_reg(REG_SCREEN_W, 1920);
        end
        1: begin
          write_reg(REG_LANE_COUNT, 1); write_reg(REG_SCROLL_T, 1);
          write_reg(REG_FIXED_T, 1); write_reg(REG_SCREEN_W, 1);
        end
        2: begin
          write_reg(REG_LANE_COUNT, 64); write_reg(REG_SCROLL_T, 65535);
          write_reg(REG_FIXED_T, 65535); write_reg(REG_FONT_SCALE, 4095);
          write_reg(REG_SCREEN_W, 8192);
        end
        3: begin
          write_reg(REG_LANE_COUNT, $urandom_range(1, 8));
          write_reg(REG_SCROLL_T, $urandom_range(1000, 12000));
          write_reg(REG_FIXED_T, $urandom_range(500, 6000));
          write_reg(REG_FONT_SCALE, $urandom_range(1, 4095));
          write_reg(REG_SCREEN_W, $urandom_range(1, 16383));
        end
        4: begin
          write_reg(REG_LANE_COUNT, 100); write_reg(REG_SCROLL_T, 0);
          write_reg(REG_FIXED_T, 3000);
        end
        default: begin
          write_reg(REG_LANE_COUNT, 12); write_reg(REG_SCROLL_T, 6000);
          write_reg(REG_FIXED_T, 0); write_reg(REG_FONT_SCALE, 300);
          write_reg(REG_SCREEN_W, 1280);
        end
      endcase
      if (ph == 3) begin
        // Hold results back long enough for the core to stall its input.
        fork
          begin
            hold_sink = 1;
            repeat (400) @(posedge clk);
            hold_sink = 0;
          end
          begin
            random_burst(20, now_ms, 200);
            drain();
          end
        join
      end
      if (ph == 7) sink_wild = 0;
      if (ph == 8) sink_wild = 1;
      random_burst(ph == 2 ? 60 : 165, now_ms, ph == 1 ? 3 : 600);
      drain();
    end

    if (board.errors == 0)
      $display("comment_lane_allocator_core test passed");
    else
      $display("comment_lane_allocator_core test failed");
    $finish;
  end
endmodule

// File: sim.f
design/cla_pkg.sv
design/cla_div.sv
design/comment_lane_allocator_core.sv
design/cla_chk.sv
tb/comment_lane_allocator_core_tb.sv
